>>> src/lfmt_pkg.sv
`timescale 1ns / 1ps

package lfmt_pkg;

    // packet framing
    localparam int unsigned PKT_W    = 36;
    localparam int unsigned LEN_W    = 6;
    localparam int unsigned ID_W     = 20;
    localparam int unsigned CRC_W    = 4;

    localparam logic [3:0]       SYNC_BITS    = 4'hF;
    localparam logic [7:0]       PATTERN_BYTE = 8'h96;
    localparam logic [LEN_W-1:0] LEN_PLAIN    = 6'd32;
    localparam logic [LEN_W-1:0] LEN_WITH_CRC = 6'd36;

    // x^i mod (x^4 + x^2 + x + 1), indexed by id bit position
    localparam logic [ID_W-1:0][CRC_W-1:0] CRC_REM = {
        4'hE, 4'h7, 4'h8, 4'h4, 4'h2, 4'h1, 4'hB, 4'hE, 4'h7, 4'h8,
        4'h4, 4'h2, 4'h1, 4'hB, 4'hE, 4'h7, 4'h8, 4'h4, 4'h2, 4'h1
    };

    // request kinds carried on tuser
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_FORM = 2'd1;
    localparam logic [1:0] MODE_SEND = 2'd2;

    typedef struct packed {
        logic [PKT_W-1:0] bits;
        logic [LEN_W-1:0] length;
    } pkt_t;

endpackage

>>> src/lfmt_pkt_form.sv
`timescale 1ns / 1ps

module lfmt_pkt_form
    import lfmt_pkg::*;
(
    input  logic [15:0] vid,
    input  logic [3:0]  sid,
    input  logic        crc_enable,
    output pkt_t        pkt
);

    logic [ID_W-1:0]  ids;
    logic [CRC_W-1:0] crc;

    assign ids = {vid, sid};

    // remainder is linear in the id bits: xor of per-bit residues
    always_comb
    begin
        crc = '0;
        for (int i = 0; i < ID_W; i++)
        begin
            if (ids[i])
                crc = crc ^ CRC_REM[i];
        end
    end

    always_comb
    begin
        if (crc_enable)
        begin
            pkt.bits   = {SYNC_BITS, PATTERN_BYTE, ids, crc};
            pkt.length = LEN_WITH_CRC;
        end
        else
        begin
            pkt.bits   = {4'b0000, SYNC_BITS, PATTERN_BYTE, ids};
            pkt.length = LEN_PLAIN;
        end
    end

endmodule

>>> src/lf_manchester_packet_transmitter_top.sv
`timescale 1ns / 1ps

// LF carrier transmitter. Each request on the slave stream is a tick, a
// form-packet request or a send request (kind on tuser); each produces exactly
// one status on the master stream: carrier level, transmit phase and the
// packet-ready flag as they stand after the request. Forming builds 1111,
// 0x96, the 16-bit vehicle id, the 4-bit node id and, when enabled, a 4-bit
// CRC of the 20 id bits modulo x^4+x^2+x+1. A send request (once a packet is
// formed) gives a carrier burst of BURST_TICKS-1 ticks, then one Manchester
// half-bit per tick, MSB first (one = on then off), and a final tick drops
// the carrier and returns to idle. Throughput is one request per clock
// while m_axis_tready stays high. An accepted request sits in the input
// register; when it steps, the state is updated and the status register
// is loaded, and the status is offered from that register. The status
// register lets a new request be taken while the previous status waits
// for tready.
module lf_manchester_packet_transmitter_top
    import lfmt_pkg::*;
#(
    parameter int unsigned BURST_TICKS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // vid[15:0], sid[19:16], crc_enable[20], zero pad
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // carrier_on[0], tx_phase[2:1], packet_ready[3], zero pad
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BURST = 2'd1,
        PH_SEND  = 2'd2
    } phase_t;

    // last burst count before bit sending starts
    localparam logic [3:0] BURST_LAST = 4'(BURST_TICKS - 1);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  mode_reg;
    logic [15:0] vid_reg;
    logic [3:0]  sid_reg;
    logic        crc_en_reg;

    // transmitter state
    logic [PKT_W-1:0] pkt_bits_reg, pkt_bits_next;
    logic [LEN_W-1:0] pkt_len_reg, pkt_len_next;
    logic [LEN_W-1:0] bits_left_reg, bits_left_next;
    logic [3:0]       burst_reg, burst_next;
    logic             half_reg, half_next;
    phase_t           phase_reg, phase_next;
    logic             ready_reg, ready_next;
    logic             carrier_reg, carrier_next;

    // status register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg;

    logic             s_accept;
    logic             step;
    pkt_t             formed;
    logic [3:0]       burst_inc;
    logic [LEN_W-1:0] bit_idx;
    logic             cur_bit;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    lfmt_pkt_form u_form
    (
        .vid        (vid_reg),
        .sid        (sid_reg),
        .crc_enable (crc_en_reg),
        .pkt        (formed)
    );

    assign burst_inc = burst_reg + 4'd1;
    assign bit_idx   = bits_left_reg - 6'd1;
    // bits_left never exceeds the longest packet length, guard kept for safety
    assign cur_bit   = (bit_idx < LEN_WITH_CRC) ? pkt_bits_reg[bit_idx] : 1'b0;

    always_comb
    begin
        pkt_bits_next  = pkt_bits_reg;
        pkt_len_next   = pkt_len_reg;
        bits_left_next = bits_left_reg;
        burst_next     = burst_reg;
        half_next      = half_reg;
        phase_next     = phase_reg;
        ready_next     = ready_reg;
        carrier_next   = carrier_reg;

        unique case (mode_reg)
            MODE_TICK:
            begin
                unique case (phase_reg)
                    PH_BURST:
                    begin
                        carrier_next = 1'b1;
                        burst_next   = burst_inc;
                        if (burst_inc >= BURST_LAST)
                        begin
                            burst_next     = '0;
                            phase_next     = PH_SEND;
                            bits_left_next = pkt_len_reg;
                        end
                    end
                    PH_SEND:
                    begin
                        if (bits_left_reg != '0)
                        begin
                            // manchester: one = on then off, zero = off then on
                            carrier_next = cur_bit ^ half_reg;
                            if (half_reg)
                                bits_left_next = bit_idx;
                            half_next = !half_reg;
                        end
                        else
                        begin
                            carrier_next = 1'b0;
                            phase_next   = PH_IDLE;
                            half_next    = 1'b0;
                        end
                    end
                    default:
                    begin
                        // idle tick: nothing moves
                    end
                endcase
            end
            MODE_FORM:
            begin
                // bits_left untouched so a running send carries on in the new packet
                pkt_bits_next = formed.bits;
                pkt_len_next  = formed.length;
                half_next     = 1'b0;
                ready_next    = 1'b1;
            end
            MODE_SEND:
            begin
                if (ready_reg)
                    phase_next = PH_BURST;
            end
            default:
            begin
                // unused kind: status only
            end
        endcase
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pkt_bits_reg  <= '0;
            pkt_len_reg   <= '0;
            bits_left_reg <= '0;
            burst_reg     <= '0;
            half_reg      <= 1'b0;
            phase_reg     <= PH_IDLE;
            ready_reg     <= 1'b0;
            carrier_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                pkt_bits_reg  <= pkt_bits_next;
                pkt_len_reg   <= pkt_len_next;
                bits_left_reg <= bits_left_next;
                burst_reg     <= burst_next;
                half_reg      <= half_next;
                phase_reg     <= phase_next;
                ready_reg     <= ready_next;
                carrier_reg   <= carrier_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            mode_reg   <= s_axis_tuser;
            vid_reg    <= s_axis_tdata[15:0];
            sid_reg    <= s_axis_tdata[19:16];
            crc_en_reg <= s_axis_tdata[20];
        end
        if (step)
            out_data_reg <= {4'b0000, ready_next, phase_next, carrier_next};
    end

    // carrier stays off whenever the transmitter is idle
    a_idle_carrier_off: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> !carrier_reg)
        else $error("carrier on while idle");

    // leaving idle needs a formed packet
    a_busy_needs_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> ready_reg)
        else $error("transmitting without a formed packet");

    // bit counter never runs past the longest packet
    a_bits_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= LEN_WITH_CRC)
        else $error("bit counter out of range");

    // each stepped request yields a status on the next cycle
    a_step_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_axis_tvalid)
        else $error("request stepped without a status");

endmodule
